// File: hw/rtl/dtq_pkg.sv
// Package for the delay timer queue: request and result structs and codes.
// No dependencies.
package dtq_pkg;

  localparam int TagBits = 16;
  localparam int DelayBits = 16;
  localparam int StampBits = 32;

  typedef enum logic [1:0] {
    RES_ACCEPT  = 2'd0,
    RES_REJECT  = 2'd1,
    RES_RELEASE = 2'd2
  } res_kind_t;

  localparam logic KIND_SCHED = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [DelayBits-1:0] delay;
    logic [TagBits-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [TagBits-1:0] out_tag;
    logic               last;
  } res_t;

endpackage

// File: hw/rtl/dtq_front.sv
// Front part: accepts requests, classifies them and places them in a
// two-entry command queue for the heap engine. Depends on dtq_pkg.
module dtq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dtq_pkg::req_t req,
  output logic          cmd_valid,
  output dtq_pkg::req_t cmd,
  input  logic          cmd_take
);
  import dtq_pkg::*;

  req_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = slot[rd_ptr];

  // Store the incoming request; a tick keeps no payload meaning.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= (req.kind == KIND_TICK) ? req_t'{kind: KIND_TICK, delay: '0, tag: '0}
                                              : req;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// File: hw/rtl/dtq_engine.sv
// Back part: the min-heap kept in a memory, sifted one level at a time,
// with a one-entry result register toward the consumer. Depends on dtq_pkg.
module dtq_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  dtq_pkg::req_t cmd,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output dtq_pkg::res_t res
);
  import dtq_pkg::*;

  localparam int IdxBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [StampBits-1:0] stamp;
    logic [TagBits-1:0]   tag;
  } ent_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPRD  = 10'b0000000010,
    S_UPCMP = 10'b0000000100,
    S_TKRD  = 10'b0000001000,
    S_TKCHK = 10'b0000010000,
    S_MVRD  = 10'b0000100000,
    S_MVWR  = 10'b0001000000,
    S_DNRDL = 10'b0010000000,
    S_DNRDR = 10'b0100000000,
    S_DNCMP = 10'b1000000000
  } state_t;

  state_t state;
  ent_t   mem [QUEUE_DEPTH];
  ent_t   rdata;
  logic [IdxBits-1:0] raddr;
  logic               rd_en;

  logic [TIME_BITS-1:0] tick_now;
  logic [StampBits-1:0] stamp_counter;
  logic [CntBits-1:0]   entry_count;
  logic [IdxBits-1:0]   pos;
  ent_t                 cur;
  ent_t                 lch;
  logic [TagBits-1:0]   pend_tag;
  logic                 have_pend;
  logic                 out_valid;
  res_t                 out_reg;

  logic                 we;
  logic [IdxBits-1:0]   waddr;
  ent_t                 wdata;
  logic                 emit;
  res_t                 emit_res;

  // Wrap-safe ordering: a releases before b.
  function automatic logic earlier(ent_t a, ent_t b, logic [StampBits-1:0] sc);
    logic [TIME_BITS-1:0] d;
    d = a.due - b.due;
    if (d != '0) return d[TIME_BITS-1];
    return (sc - a.stamp) > (sc - b.stamp);
  endfunction

  // Heap store with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // Heap index arithmetic and child presence.
  logic [IdxBits-1:0] parent, lidx, ridx;
  logic [IdxBits+1:0] lwide, rwide, cnt_wide;
  logic               has_l, has_r;
  assign parent   = (pos - IdxBits'(1)) >> 1;
  assign lwide    = {1'b0, pos, 1'b1};
  assign rwide    = lwide + (IdxBits+2)'(1);
  assign cnt_wide = (IdxBits+2)'(entry_count);
  assign lidx     = lwide[IdxBits-1:0];
  assign ridx     = rwide[IdxBits-1:0];
  assign has_l    = (lwide < cnt_wide);
  assign has_r    = (rwide < cnt_wide);

  // Decisions shared by the steering and the sequencer.
  logic [TIME_BITS-1:0] age;
  logic                 up_move, due_now, l_win, r_win, tk_go, full_store;
  assign age        = tick_now - rdata.due;
  assign up_move    = earlier(cur, rdata, stamp_counter);
  assign due_now    = (entry_count != '0) && !age[TIME_BITS-1];
  assign l_win      = earlier(lch, cur, stamp_counter);
  assign r_win      = has_r && (l_win ? earlier(rdata, lch, stamp_counter)
                                      : earlier(rdata, cur, stamp_counter));
  assign tk_go      = !(have_pend && out_valid);
  assign full_store = (entry_count == CntBits'(QUEUE_DEPTH));

  assign empty    = !out_valid;
  assign res      = out_reg;
  assign cmd_take = (state == S_IDLE) && cmd_valid && !out_valid;

  // Read address, write port and result steering.
  always_comb begin
    rd_en    = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = pos;
    wdata    = cur;
    emit     = 1'b0;
    emit_res = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_take && cmd.kind == KIND_SCHED && full_store) begin
          emit     = 1'b1;
          emit_res = '{result_kind: RES_REJECT, out_tag: cmd.tag, last: 1'b1};
        end
      end
      S_UPRD: begin
        // The root needs no parent read; the new entry settles there.
        if (pos == '0) begin
          we       = 1'b1;
          emit     = 1'b1;
          emit_res = '{result_kind: RES_ACCEPT, out_tag: cur.tag, last: 1'b1};
        end else begin
          rd_en = 1'b1;
          raddr = parent;
        end
      end
      S_UPCMP: begin
        // Move the parent down when the new entry is earlier, else settle.
        we = 1'b1;
        if (up_move) begin
          wdata = rdata;
        end else begin
          emit     = 1'b1;
          emit_res = '{result_kind: RES_ACCEPT, out_tag: cur.tag, last: 1'b1};
        end
      end
      S_TKRD: begin
        rd_en = 1'b1;
        raddr = '0;
      end
      S_TKCHK: begin
        // A held release goes out once it is known whether another follows.
        if (tk_go && have_pend) begin
          emit     = 1'b1;
          emit_res = '{result_kind: RES_RELEASE, out_tag: pend_tag, last: !due_now};
        end
      end
      S_MVRD: begin
        rd_en = 1'b1;
        raddr = entry_count[IdxBits-1:0];
      end
      S_MVWR: begin
      end
      S_DNRDL: begin
        if (has_l) begin
          rd_en = 1'b1;
          raddr = lidx;
        end else begin
          we = 1'b1;
        end
      end
      S_DNRDR: begin
        rd_en = has_r;
        raddr = ridx;
      end
      S_DNCMP: begin
        // Pull up the earliest child, or settle the moved entry here.
        we = 1'b1;
        if (r_win) wdata = rdata;
        else if (l_win) wdata = lch;
      end
      default: begin
      end
    endcase
  end

  // Result register: filled only while empty, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_reg <= emit_res;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_now      <= '0;
      stamp_counter <= '0;
      entry_count   <= '0;
      pos           <= '0;
      have_pend     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd.kind == KIND_TICK) begin
              tick_now <= tick_now + TIME_BITS'(1);
              state    <= S_TKRD;
            end else if (!full_store) begin
              cur <= '{due: tick_now + TIME_BITS'(cmd.delay), stamp: stamp_counter,
                       tag: cmd.tag};
              pos           <= entry_count[IdxBits-1:0];
              stamp_counter <= stamp_counter + StampBits'(1);
              entry_count   <= entry_count + CntBits'(1);
              state         <= S_UPRD;
            end
          end
        end
        S_UPRD: state <= (pos == '0) ? S_IDLE : S_UPCMP;
        S_UPCMP: begin
          if (up_move) begin
            pos   <= parent;
            state <= S_UPRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TKRD: state <= S_TKCHK;
        S_TKCHK: begin
          if (tk_go) begin
            if (due_now) begin
              pend_tag    <= rdata.tag;
              have_pend   <= 1'b1;
              entry_count <= entry_count - CntBits'(1);
              state       <= (entry_count == CntBits'(1)) ? S_TKRD : S_MVRD;
            end else begin
              have_pend <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        S_MVRD: state <= S_MVWR;
        S_MVWR: begin
          cur   <= rdata;
          pos   <= '0;
          state <= S_DNRDL;
        end
        S_DNRDL: state <= has_l ? S_DNRDR : S_TKRD;
        S_DNRDR: begin
          lch   <= rdata;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (r_win) begin
            pos   <= ridx;
            state <= S_DNRDL;
          end else if (l_win) begin
            pos   <= lidx;
            state <= S_DNRDL;
          end else begin
            state <= S_TKRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/delay_timer_queue.sv
// Top level of the delay timer queue. Instantiates dtq_front and dtq_engine.
// Depends on dtq_pkg.
//
// Usage: requests enter through push/full as dtq_pkg::req_t. A schedule
// stores a tag due at the current tick plus delay and answers accepted, or
// rejected when all QUEUE_DEPTH slots are used. A tick advances time and
// releases every due tag, earliest first, ties in scheduling order; the last
// result of a request has last set. Results leave through empty/pop.
// A schedule answer follows one parent read and compare per level of the
// heap. A tick reads the heap root; each release then moves the last entry
// to the root and sifts it down, and is shown once the next root is checked,
// so last is known.
// Throughput: the engine works on one request at a time; a two-entry queue
// decouples the input from it.
// Reset empties the heap and zeroes tick time.
// When the consumer stalls, the engine holds its result register and waits;
// the input queue then fills and full rises.
module delay_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dtq_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output dtq_pkg::res_t res
);
  import dtq_pkg::*;

  logic cmd_valid, cmd_take;
  req_t cmd;

  dtq_front u_front (
    .clk, .rst, .push, .full, .req, .cmd_valid, .cmd, .cmd_take
  );

  dtq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .res
  );
endmodule

// File: hw/rtl/dtq_checker.sv
// Port-level checks for the delay timer queue, bound to the top level.
// Depends on dtq_pkg.
module dtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          empty,
  input logic          pop,
  input dtq_pkg::res_t res
);
  import dtq_pkg::*;

  // A waiting result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(res)) else $error("result dropped");

  // Result codes are meaningful.
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (res.result_kind == RES_ACCEPT || res.result_kind == RES_REJECT ||
                res.result_kind == RES_RELEASE)) else $error("bad result code");

  // Schedule answers always close their request.
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty && res.result_kind != RES_RELEASE |-> res.last)
    else $error("schedule answer without last");

  // Reset leaves no result waiting.
  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");
endmodule

bind delay_timer_queue dtq_checker u_chk (
  .clk, .rst, .empty, .pop, .res
);
